// ===== design/interpolating_lut_evaluator_core_defines.svh =====
// ----------------------------------------------------------------------------
// interpolating lut evaluator assertion macros
// property wrappers that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef INTERPOLATING_LUT_EVALUATOR_CORE_DEFINES_SVH
`define INTERPOLATING_LUT_EVALUATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ILUT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ILUT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ILUT_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ILUT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== design/ilut_pkg.sv =====
// ----------------------------------------------------------------------------
// ilut_pkg
// shared types and constants of the interpolating lookup table evaluator
// ----------------------------------------------------------------------------
package ilut_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = 11;
   localparam int DIVD_W      = 64;
   localparam int DIVS_W      = 34;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_FORWARD = 2'd1,
      CMD_INVERSE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_RANGE_LOW      = 2'd0,
      CSR_RANGE_HIGH     = 2'd1,
      CSR_POSITION_SCALE = 2'd2,
      CSR_ENTRIES_IN_USE = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_MUL,
      ST_FWD_CHK,
      ST_FWD_RDA,
      ST_FWD_RDB,
      ST_FWD_SUM,
      ST_RD_END,
      ST_INV_RD0,
      ST_INV_RDN,
      ST_INV_STEP,
      ST_INV_CMP,
      ST_INV_DIV1,
      ST_INV_MLO,
      ST_INV_MHI,
      ST_INV_DST,
      ST_INV_DIV2
   } state_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [ADDR_W-1:0]   entry_index;
      logic signed [31:0]  operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  result_value;
      logic                within_range;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [DIVD_W-1:0]   dividend;
      logic [DIVS_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIVD_W-1:0]   quotient;
      logic                rem_nz;
   } div_rsp_type;

endpackage

// ===== design/interpolating_lut_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// interpolating_lut_evaluator_core
// lookup table with entry write, clamped linear interpolation and inverse
// write answers from idle; the inverse finishes at the table ends, else
// it runs a binary search over the table followed by two divides
// one request at a time, busy high while a request is in work
// reset restores the register defaults; table contents stay undefined
// ----------------------------------------------------------------------------
`include "interpolating_lut_evaluator_core_defines.svh"

module interpolating_lut_evaluator_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ilut_pkg::req_type     req_data,
   output logic                  rsp_valid,
   output ilut_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);

   localparam int AW = ilut_pkg::ADDR_W;
   localparam int CW = ilut_pkg::COUNT_W;

   ilut_pkg::state_type       state_ff, state_in;
   logic signed [31:0]        range_low_ff, range_high_ff;
   logic [31:0]               position_scale_ff;
   logic [CW-1:0]             entries_ff;

   logic signed [31:0]        op_ff, op_in;
   logic signed [32:0]        diff_ff, diff_in;
   logic [CW-1:0]             n_ff, n_in;
   logic [63:0]               p_ff, p_in;
   logic signed [31:0]        a_ff, a_in;
   logic signed [49:0]        mix_ff, mix_in;
   logic signed [31:0]        y0_ff, y0_in, y1_ff, y1_in;
   logic                      inc_ff, inc_in, flag_ff, flag_in;
   logic [AW-1:0]             low_ff, low_in, high_ff, high_in, idx_ff, idx_in;
   logic [26:0]               pos_ff, pos_in;
   logic signed [60:0]        acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ilut_pkg::rsp_type         rsp_ff, rsp_in;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [31:0]               ram_wdata, ram_rdata;
   logic signed [31:0]        rd_val;
   ilut_pkg::div_req_type     div_req;
   ilut_pkg::div_rsp_type     div_rsp;

   logic [63:0]               fwd_prod;
   logic signed [32:0]        slope, span, num_s, den_s;
   logic signed [49:0]        mix_prod, inv_lo;
   logic signed [44:0]        inv_hi;
   logic [CW-1:0]             n_start, nm1;
   logic [10:0]               mid_sum;
   logic                      rd_inc, rd_lo_hit, rd_hi_hit;
   logic signed [31:0]        rd_min, rd_max;
   logic                      acc_neg;
   logic [60:0]               acc_abs;
   logic [31:0]               q_adj;

   function automatic logic [32:0] abs33(input logic signed [32:0] v);
      abs33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

   ilut_ram #(.WIDTH(32), .DEPTH(ilut_pkg::TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ilut_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff      <= 32'sd0;
         range_high_ff     <= 32'sd65536;
         position_scale_ff <= '0;
         entries_ff        <= '0;
      end else if (csr_valid) begin
         case (ilut_pkg::csr_type'(csr_index))
            ilut_pkg::CSR_RANGE_LOW:      range_low_ff      <= csr_data;
            ilut_pkg::CSR_RANGE_HIGH:     range_high_ff     <= csr_data;
            ilut_pkg::CSR_POSITION_SCALE: position_scale_ff <= csr_data;
            ilut_pkg::CSR_ENTRIES_IN_USE: entries_ff        <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilut_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      diff_ff <= diff_in;
      n_ff    <= n_in;
      p_ff    <= p_in;
      a_ff    <= a_in;
      mix_ff  <= mix_in;
      y0_ff   <= y0_in;
      y1_ff   <= y1_in;
      inc_ff  <= inc_in;
      flag_ff <= flag_in;
      low_ff  <= low_in;
      high_ff <= high_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign rd_val    = ram_rdata;
   assign fwd_prod  = diff_ff[31:0] * position_scale_ff;
   assign slope     = $signed({rd_val[31], rd_val}) - $signed({a_ff[31], a_ff});
   assign mix_prod  = slope * $signed({1'b0, p_ff[31:16]});
   assign span      = $signed({range_high_ff[31], range_high_ff})
                      - $signed({range_low_ff[31], range_low_ff});
   assign inv_lo    = span * $signed({1'b0, pos_ff[15:0]});
   assign inv_hi    = span * $signed({1'b0, pos_ff[26:16]});
   assign n_start   = (entries_ff > CW'(ilut_pkg::TABLE_DEPTH))
                      ? CW'(ilut_pkg::TABLE_DEPTH) : entries_ff;
   assign nm1       = n_ff - 1'b1;
   assign mid_sum   = {1'b0, low_ff} + {1'b0, high_ff};
   assign num_s     = $signed({op_ff[31], op_ff}) - $signed({y0_ff[31], y0_ff});
   assign den_s     = $signed({y1_ff[31], y1_ff}) - $signed({y0_ff[31], y0_ff});
   assign rd_inc    = y0_ff < rd_val;
   assign rd_min    = rd_inc ? y0_ff : rd_val;
   assign rd_max    = rd_inc ? rd_val : y0_ff;
   assign rd_lo_hit = rd_inc ? (op_ff <= y0_ff) : (op_ff >= y0_ff);
   assign rd_hi_hit = rd_inc ? (op_ff >= rd_val) : (op_ff <= rd_val);
   assign acc_neg   = acc_ff[60];
   assign acc_abs   = acc_neg ? 61'(-acc_ff) : 61'(acc_ff);
   assign q_adj     = acc_neg ? (32'(-div_rsp.quotient[31:0]) - 32'(div_rsp.rem_nz))
                              : div_rsp.quotient[31:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      diff_in      = diff_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      a_in         = a_ff;
      mix_in       = mix_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      inc_in       = inc_ff;
      flag_in      = flag_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = req_data.entry_index;
      ram_wdata    = req_data.operand;
      ram_raddr    = '0;
      div_req      = '0;
      case (state_ff)
         ilut_pkg::ST_IDLE: begin
            if (start) begin
               op_in   = req_data.operand;
               n_in    = n_start;
               diff_in = $signed({req_data.operand[31], req_data.operand})
                         - $signed({range_low_ff[31], range_low_ff});
               case (ilut_pkg::cmd_type'(req_data.command))
                  ilut_pkg::CMD_WRITE: begin
                     ram_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_value: 32'sd0, within_range: 1'b0};
                  end
                  ilut_pkg::CMD_FORWARD: begin
                     flag_in = (req_data.operand >= range_low_ff)
                               && (req_data.operand <= range_high_ff);
                     if (n_start < CW'(2)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{result_value: 32'sd0, within_range: flag_in};
                     end else if (diff_in[32]) begin
                        ram_raddr = '0;
                        state_in  = ilut_pkg::ST_RD_END;
                     end else begin
                        state_in  = ilut_pkg::ST_FWD_MUL;
                     end
                  end
                  ilut_pkg::CMD_INVERSE: begin
                     if (n_start < CW'(2)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{result_value: range_low_ff, within_range: 1'b0};
                     end else begin
                        ram_raddr = '0;
                        state_in  = ilut_pkg::ST_INV_RD0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{result_value: 32'sd0, within_range: 1'b0};
                  end
               endcase
            end
         end
         ilut_pkg::ST_FWD_MUL: begin
            p_in     = fwd_prod;
            state_in = ilut_pkg::ST_FWD_CHK;
         end
         ilut_pkg::ST_FWD_CHK: begin
            if (p_ff[63:32] >= {21'b0, nm1}) begin
               ram_raddr = nm1[AW-1:0];
               state_in  = ilut_pkg::ST_RD_END;
            end else begin
               idx_in    = p_ff[32+AW-1:32];
               ram_raddr = p_ff[32+AW-1:32];
               state_in  = ilut_pkg::ST_FWD_RDA;
            end
         end
         ilut_pkg::ST_FWD_RDA: begin
            a_in      = rd_val;
            ram_raddr = idx_ff + 1'b1;
            state_in  = ilut_pkg::ST_FWD_RDB;
         end
         ilut_pkg::ST_FWD_RDB: begin
            mix_in   = mix_prod;
            state_in = ilut_pkg::ST_FWD_SUM;
         end
         ilut_pkg::ST_FWD_SUM: begin
            rsp_valid_in = 1'b1;
            rsp_in   = '{result_value: a_ff + $signed(mix_ff[47:16]), within_range: flag_ff};
            state_in = ilut_pkg::ST_IDLE;
         end
         ilut_pkg::ST_RD_END: begin
            rsp_valid_in = 1'b1;
            rsp_in   = '{result_value: rd_val, within_range: flag_ff};
            state_in = ilut_pkg::ST_IDLE;
         end
         ilut_pkg::ST_INV_RD0: begin
            y0_in     = rd_val;
            ram_raddr = nm1[AW-1:0];
            state_in  = ilut_pkg::ST_INV_RDN;
         end
         ilut_pkg::ST_INV_RDN: begin
            y1_in   = rd_val;
            inc_in  = rd_inc;
            flag_in = (op_ff >= rd_min) && (op_ff <= rd_max);
            low_in  = '0;
            high_in = nm1[AW-1:0];
            if (rd_lo_hit) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{result_value: range_low_ff, within_range: flag_in};
               state_in = ilut_pkg::ST_IDLE;
            end else if (rd_hi_hit) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{result_value: range_high_ff, within_range: flag_in};
               state_in = ilut_pkg::ST_IDLE;
            end else begin
               state_in = ilut_pkg::ST_INV_STEP;
            end
         end
         ilut_pkg::ST_INV_STEP: begin
            if (high_ff - low_ff > AW'(1)) begin
               idx_in    = mid_sum[AW:1];
               ram_raddr = mid_sum[AW:1];
               state_in  = ilut_pkg::ST_INV_CMP;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {15'b0, abs33(num_s), 16'b0};
               div_req.divisor  = {1'b0, abs33(den_s)};
               state_in         = ilut_pkg::ST_INV_DIV1;
            end
         end
         ilut_pkg::ST_INV_CMP: begin
            if (inc_ff ? (rd_val < op_ff) : (rd_val > op_ff)) begin
               low_in = idx_ff;
               y0_in  = rd_val;
            end else begin
               high_in = idx_ff;
               y1_in   = rd_val;
            end
            state_in = ilut_pkg::ST_INV_STEP;
         end
         ilut_pkg::ST_INV_DIV1: begin
            if (div_rsp.done) begin
               pos_in   = {1'b0, low_ff, 16'b0} + {10'b0, div_rsp.quotient[16:0]};
               state_in = ilut_pkg::ST_INV_MLO;
            end
         end
         ilut_pkg::ST_INV_MLO: begin
            acc_in   = {{11{inv_lo[49]}}, inv_lo};
            state_in = ilut_pkg::ST_INV_MHI;
         end
         ilut_pkg::ST_INV_MHI: begin
            acc_in   = acc_ff + $signed({inv_hi, 16'b0});
            state_in = ilut_pkg::ST_INV_DST;
         end
         ilut_pkg::ST_INV_DST: begin
            div_req.start    = 1'b1;
            div_req.dividend = {3'b0, acc_abs};
            div_req.divisor  = {8'b0, nm1[AW-1:0], 16'b0};
            state_in         = ilut_pkg::ST_INV_DIV2;
         end
         ilut_pkg::ST_INV_DIV2: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_in   = '{result_value: range_low_ff + $signed(q_adj),
                            within_range: flag_ff};
               state_in = ilut_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ilut_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != ilut_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `ILUT_ASSERT_NEXT(a_start_progress, clock, reset, start && !busy, busy || rsp_valid)
   `ILUT_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `ILUT_ASSERT_IMPLY(a_cmp_after_step, clock, reset, state_ff == ilut_pkg::ST_INV_CMP, $past(state_ff) == ilut_pkg::ST_INV_STEP)

endmodule

// ===== design/ilut_ram.sv =====
// ----------------------------------------------------------------------------
// ilut_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ilut_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ilut_divider.sv =====
// ----------------------------------------------------------------------------
// ilut_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ilut_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ilut_pkg::div_req_type div_req,
   output ilut_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(ilut_pkg::DIVD_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [ilut_pkg::DIVD_W-1:0]   quo_ff, quo_in;
   logic [ilut_pkg::DIVS_W-1:0]   rem_ff, rem_in;
   logic [ilut_pkg::DIVS_W-1:0]   den_ff, den_in;
   logic [ilut_pkg::DIVS_W:0]     rem_sh;
   logic                          ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      rem_sh   = {rem_ff, quo_ff[ilut_pkg::DIVD_W-1]};
      ge       = rem_sh >= {1'b0, den_ff};
      if (div_req.start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = div_req.dividend;
         rem_in   = '0;
         den_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? ilut_pkg::DIVS_W'(rem_sh - {1'b0, den_ff})
                       : rem_sh[ilut_pkg::DIVS_W-1:0];
         quo_in   = {quo_ff[ilut_pkg::DIVD_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (&count_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.rem_nz   = |rem_ff;

endmodule
